/* hw/rtl/mdf_pkg.sv */
`timescale 1ns / 1ps

package mdf_pkg;

  localparam int StoreDepthDefault = 64;

  localparam logic [2:0] VERDICT_SELF  = 3'd0;
  localparam logic [2:0] VERDICT_LOOP  = 3'd1;
  localparam logic [2:0] VERDICT_TTL   = 3'd2;
  localparam logic [2:0] VERDICT_DUP   = 3'd3;
  localparam logic [2:0] VERDICT_FWD   = 3'd4;
  localparam logic [2:0] VERDICT_UPPER = 3'd5;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_CLEAN  = 1'b1;

  // multiply by ceil(2^17/3) and keep the top bits: exact floor(n/3) for 16-bit n
  localparam logic [32:0] DIV3_RECIP = 33'h0AAAB;
  localparam int          DIV3_SHIFT = 17;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // search token travelling down the cell chain
  typedef struct packed {
    logic token;
    logic hit;
  } link_t;

endpackage

/* hw/rtl/mdf_cell.sv */
`timescale 1ns / 1ps

module mdf_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift_en,
  input  logic [31:0]     sig_in,
  output logic [31:0]     sig_out,
  input  logic [CNT_W-1:0] count,
  input  logic [31:0]     query_sig,
  input  mdf_pkg::link_t  link_in,
  output mdf_pkg::link_t  link_out
);

  logic [31:0]    sig;
  mdf_pkg::link_t link;
  logic           valid;

  // cells are in age order, youngest at index zero
  assign valid = (count > CNT_W'(INDEX));

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sig <= sig_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link <= '0;
    end else begin
      link.token <= link_in.token;
      link.hit   <= link_in.hit | (link_in.token & valid & (sig == query_sig));
    end
  end

  assign sig_out  = sig;
  assign link_out = link;

endmodule

/* hw/rtl/multicast_duplicate_filter.sv */
`timescale 1ns / 1ps
// packet beat: discards on self, loop or zero ttl give the result in the cycle after start
// otherwise launch is registered and the lookup token walks the cell chain, done registered at its end
// no new packet is accepted until that walk ends; a clean tick updates count, leaves busy low, no done
// busy is high while a lookup runs; the result strobe done lasts one cycle, no stall
// rst (synchronous) empties the store and clears local_addr

module multicast_duplicate_filter #(
  parameter int STORE_DEPTH = mdf_pkg::StoreDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [7:0]  ttl_in,
  input  logic [3:0]  in_iface,
  input  logic [31:0] packet_signature,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [2:0]  verdict,
  output logic [7:0]  ttl_out,
  output logic [3:0]  out_iface
);

  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  mdf_pkg::state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [31:0]      local_addr;
  logic             launch, launch_next;
  logic [31:0]      q_sig;
  logic             q_mcast;
  logic [7:0]       q_ttl;
  logic [3:0]       q_iface;
  logic             done_next;
  logic [2:0]       verdict_next;
  logic [7:0]       ttl_out_next;
  logic [3:0]       out_iface_next;
  logic             accept;
  logic             shift_en;
  logic [15:0]      cnt_wide;
  logic [32:0]      prod;
  logic [CNT_W-1:0] drop;

  mdf_pkg::link_t   links [STORE_DEPTH+1];
  logic [31:0]      sigs  [STORE_DEPTH+1];

  assign links[0] = '{token: launch, hit: 1'b0};
  assign sigs[0]  = q_sig;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    mdf_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_en  (shift_en),
      .sig_in    (sigs[i]),
      .sig_out   (sigs[i+1]),
      .count     (count),
      .query_sig (q_sig),
      .link_in   (links[i]),
      .link_out  (links[i+1])
    );
  end

  assign busy   = (state != mdf_pkg::ST_IDLE);
  assign accept = start & ~busy;

  // clean tick drops floor(count / 3) oldest entries
  assign cnt_wide = 16'(count);
  assign prod     = {17'b0, cnt_wide} * mdf_pkg::DIV3_RECIP;
  assign drop     = CNT_W'(prod[32:mdf_pkg::DIV3_SHIFT]);

  always_comb begin
    state_next     = state;
    count_next     = count;
    launch_next    = 1'b0;
    done_next      = 1'b0;
    verdict_next   = verdict;
    ttl_out_next   = 8'd0;
    out_iface_next = 4'd0;
    shift_en       = 1'b0;
    case (state)
      mdf_pkg::ST_IDLE: begin
        if (accept) begin
          if (command == mdf_pkg::CMD_CLEAN) begin
            count_next = count - drop;
          end else if (src_addr == local_addr) begin
            done_next    = 1'b1;
            verdict_next = mdf_pkg::VERDICT_SELF;
          end else if (dst_addr == src_addr) begin
            done_next    = 1'b1;
            verdict_next = mdf_pkg::VERDICT_LOOP;
          end else if (ttl_in == 8'd0) begin
            done_next    = 1'b1;
            verdict_next = mdf_pkg::VERDICT_TTL;
          end else begin
            launch_next = 1'b1;
            state_next  = mdf_pkg::ST_SEARCH;
          end
        end
      end
      mdf_pkg::ST_SEARCH: begin
        if (links[STORE_DEPTH].token) begin
          state_next = mdf_pkg::ST_IDLE;
          done_next  = 1'b1;
          if (links[STORE_DEPTH].hit) begin
            verdict_next = mdf_pkg::VERDICT_DUP;
          end else begin
            // full store: the oldest entry falls off the end of the chain
            shift_en = 1'b1;
            if (count != CNT_W'(STORE_DEPTH)) begin
              count_next = count + CNT_W'(1);
            end
            if (q_mcast) begin
              verdict_next   = mdf_pkg::VERDICT_FWD;
              ttl_out_next   = q_ttl - 8'd1;
              out_iface_next = q_iface;
            end else begin
              verdict_next = mdf_pkg::VERDICT_UPPER;
            end
          end
        end
      end
      default: begin
        state_next = mdf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mdf_pkg::ST_IDLE;
      count      <= '0;
      launch     <= 1'b0;
      done       <= 1'b0;
      local_addr <= 32'd0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      launch <= launch_next;
      done   <= done_next;
      if (cfg_we) begin
        local_addr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    verdict   <= verdict_next;
    ttl_out   <= ttl_out_next;
    out_iface <= out_iface_next;
    if (accept) begin
      q_sig   <= packet_signature;
      q_mcast <= (dst_addr[31:28] == 4'hE);
      q_ttl   <= ttl_in;
      q_iface <= in_iface;
    end
  end

endmodule
